@@ hdl/grff_pkg.sv @@
`default_nettype none

package grff_pkg;

  localparam int GRID_REG_W = 7;
  localparam int COUNT_W    = 13;

  localparam logic [GRID_REG_W-1:0] GRID_RESET = 7'd64;

  typedef enum logic [1:0] {
    KIND_WRITE   = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_RESOLVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CELL_EMPTY    = 2'd0,
    CELL_CAPTURED = 2'd1,
    CELL_TRAIL    = 2'd2,
    CELL_MARKED   = 2'd3
  } cell_e;

  typedef enum logic {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_e;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_RIGHT = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILL_SEED,
    ST_PROBE,
    ST_CHECK,
    ST_POP,
    ST_RES_RUN,
    ST_RES_TAIL
  } state_e;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] col;
    logic [5:0] row;
    logic [1:0] cell_code;
  } item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] cell_count;
    logic [1:0]         done_kind;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/grff_ram.sv @@
`default_nettype none

module grff_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/grid_region_flood_fill.sv @@
`default_nettype none

// Channel   Direction  Handshake              Payload
// command   in         start high, busy low   item_i   (kind, col, row, cell_code)
// result    out        done_o, one cycle      result_o (cell_count, done_kind)
// config    in         cfg_we_i               cfg_idx_i, cfg_data_i
//
// A write word, or a word of an unused kind, is handled in idle and busy stays low.
// A fill from a seed outside the grid, or a resolve of an empty grid, is handled likewise.
// A fill reads the seed cell, then probes the neighbors of the current cell in the order
// up, down, left, right, steps into the first empty one inside the grid and pushes the
// current cell, and pops the stack when none is left; a resolve rewrites every grid cell.
// The result appears the cycle after the word finishes. Reset is asynchronous and
// the memories hold no reset state. The receiver cannot stall results.

module grid_region_flood_fill #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  grff_pkg::item_t                    item_i,
  output logic                               done_o,
  output grff_pkg::result_t                  result_o,
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [grff_pkg::GRID_REG_W-1:0]    cfg_data_i
);

  import grff_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int AW     = CW + RW;
  localparam int CDEPTH = 2 ** AW;
  localparam int SDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int SAW    = $clog2(SDEPTH);
  localparam int SLW    = $clog2(SDEPTH + 1);
  localparam int XW     = (CW > RW) ? CW : RW;
  localparam int CMPW   = (XW + 1 > GRID_REG_W) ? XW + 1 : GRID_REG_W;

  state_e                 state_q, state_d;
  logic [GRID_REG_W-1:0]  grid_w_q, grid_h_q;
  logic [CW-1:0]          cur_c_q, cur_c_d;
  logic [RW-1:0]          cur_r_q, cur_r_d;
  dir_e                   dir_q, dir_d;
  logic [SLW-1:0]         level_q, level_d;
  logic [COUNT_W-1:0]     count_q, count_d;
  logic [CW-1:0]          scan_c_q, scan_c_d;
  logic [RW-1:0]          scan_r_q, scan_r_d;
  logic                   scan_v_q, scan_v_d;
  logic [AW-1:0]          scan_a_q, scan_a_d;
  logic                   done_q, done_d;
  result_t                result_q, result_d;

  logic                   c_we, c_re;
  logic [AW-1:0]          c_waddr, c_raddr;
  logic [1:0]             c_wdata, c_rdata;
  logic                   s_we, s_re;
  logic [SAW-1:0]         s_waddr, s_raddr;
  logic [AW-1:0]          s_wdata, s_rdata;

  logic [CMPW-1:0]        eff_w, eff_h;
  logic [CMPW-1:0]        seed_c_x, seed_r_x;
  logic                   seed_in, wr_in_store;
  logic [CW-1:0]          nb_c;
  logic [RW-1:0]          nb_r;
  logic                   nb_ok;
  logic                   pop_req, res_wb, res_inc;
  logic [SLW-1:0]         level_m1;

  assign eff_w = (CMPW'(grid_w_q) > CMPW'(MAX_WIDTH))  ? CMPW'(MAX_WIDTH)  : CMPW'(grid_w_q);
  assign eff_h = (CMPW'(grid_h_q) > CMPW'(MAX_HEIGHT)) ? CMPW'(MAX_HEIGHT) : CMPW'(grid_h_q);

  assign seed_c_x    = CMPW'(item_i.col);
  assign seed_r_x    = CMPW'(item_i.row);
  assign seed_in     = (seed_c_x < eff_w) && (seed_r_x < eff_h);
  assign wr_in_store = (seed_c_x < CMPW'(MAX_WIDTH)) && (seed_r_x < CMPW'(MAX_HEIGHT));

  assign level_m1 = level_q - 1'b1;
  assign res_inc  = (c_rdata == CELL_MARKED);
  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = result_q;

  always_comb begin
    nb_c  = cur_c_q;
    nb_r  = cur_r_q;
    nb_ok = 1'b0;
    unique case (dir_q)
      DIR_UP: begin
        nb_ok = (cur_r_q != '0);
        nb_r  = cur_r_q - 1'b1;
      end
      DIR_DOWN: begin
        nb_ok = (CMPW'(cur_r_q) + 1'b1) < eff_h;
        nb_r  = cur_r_q + 1'b1;
      end
      DIR_LEFT: begin
        nb_ok = (cur_c_q != '0);
        nb_c  = cur_c_q - 1'b1;
      end
      DIR_RIGHT: begin
        nb_ok = (CMPW'(cur_c_q) + 1'b1) < eff_w;
        nb_c  = cur_c_q + 1'b1;
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cur_c_d  = cur_c_q;
    cur_r_d  = cur_r_q;
    dir_d    = dir_q;
    level_d  = level_q;
    count_d  = count_q;
    scan_c_d = scan_c_q;
    scan_r_d = scan_r_q;
    scan_v_d = 1'b0;
    scan_a_d = scan_a_q;
    done_d   = 1'b0;
    result_d = result_q;
    c_we     = 1'b0;
    c_waddr  = '0;
    c_wdata  = CELL_EMPTY;
    c_re     = 1'b0;
    c_raddr  = '0;
    s_we     = 1'b0;
    s_waddr  = '0;
    s_wdata  = '0;
    s_re     = 1'b0;
    s_raddr  = '0;
    pop_req  = 1'b0;
    res_wb   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          result_d.cell_count = '0;
          result_d.done_kind  = item_i.kind;
          done_d              = 1'b1;
          if (item_i.kind == KIND_FILL) begin
            if (seed_in) begin
              done_d  = 1'b0;
              cur_c_d = seed_c_x[CW-1:0];
              cur_r_d = seed_r_x[RW-1:0];
              s_we    = 1'b1;
              s_waddr = '0;
              s_wdata = {seed_r_x[RW-1:0], seed_c_x[CW-1:0]};
              level_d = SLW'(1);
              c_re    = 1'b1;
              c_raddr = {seed_r_x[RW-1:0], seed_c_x[CW-1:0]};
              count_d = '0;
              state_d = ST_FILL_SEED;
            end
          end else if (item_i.kind == KIND_RESOLVE) begin
            if ((eff_w != '0) && (eff_h != '0)) begin
              done_d   = 1'b0;
              scan_c_d = '0;
              scan_r_d = '0;
              count_d  = '0;
              state_d  = ST_RES_RUN;
            end
          end else if ((item_i.kind == KIND_WRITE) && wr_in_store) begin
            c_we    = 1'b1;
            c_waddr = {seed_r_x[RW-1:0], seed_c_x[CW-1:0]};
            c_wdata = item_i.cell_code;
          end
        end
      end
      ST_FILL_SEED: begin
        if (c_rdata == CELL_EMPTY) begin
          c_we    = 1'b1;
          c_waddr = {cur_r_q, cur_c_q};
          c_wdata = CELL_MARKED;
          count_d = count_q + 1'b1;
        end
        dir_d   = DIR_UP;
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (nb_ok) begin
          c_re    = 1'b1;
          c_raddr = {nb_r, nb_c};
          state_d = ST_CHECK;
        end else if (dir_q == DIR_RIGHT) begin
          pop_req = 1'b1;
        end else begin
          dir_d = dir_e'(dir_q + 2'd1);
        end
      end
      ST_CHECK: begin
        if (c_rdata == CELL_EMPTY) begin
          s_we    = 1'b1;
          s_waddr = level_q[SAW-1:0];
          s_wdata = {cur_r_q, cur_c_q};
          level_d = level_q + 1'b1;
          c_we    = 1'b1;
          c_waddr = {nb_r, nb_c};
          c_wdata = CELL_MARKED;
          count_d = count_q + 1'b1;
          cur_c_d = nb_c;
          cur_r_d = nb_r;
          dir_d   = DIR_UP;
          state_d = ST_PROBE;
        end else if (dir_q == DIR_RIGHT) begin
          pop_req = 1'b1;
        end else begin
          dir_d   = dir_e'(dir_q + 2'd1);
          state_d = ST_PROBE;
        end
      end
      ST_POP: begin
        cur_c_d = s_rdata[CW-1:0];
        cur_r_d = s_rdata[AW-1:CW];
        dir_d   = DIR_UP;
        state_d = ST_PROBE;
      end
      ST_RES_RUN: begin
        c_re     = 1'b1;
        c_raddr  = {scan_r_q, scan_c_q};
        scan_v_d = 1'b1;
        scan_a_d = {scan_r_q, scan_c_q};
        if ((CMPW'(scan_c_q) + 1'b1) == eff_w) begin
          scan_c_d = '0;
          if ((CMPW'(scan_r_q) + 1'b1) == eff_h) begin
            state_d = ST_RES_TAIL;
          end else begin
            scan_r_d = scan_r_q + 1'b1;
          end
        end else begin
          scan_c_d = scan_c_q + 1'b1;
        end
        res_wb = scan_v_q;
      end
      ST_RES_TAIL: begin
        res_wb              = 1'b1;
        done_d              = 1'b1;
        result_d.cell_count = count_q + COUNT_W'(res_inc);
        result_d.done_kind  = KIND_RESOLVE;
        state_d             = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (pop_req) begin
      level_d = level_m1;
      if (level_m1 == '0) begin
        done_d              = 1'b1;
        result_d.cell_count = count_q;
        result_d.done_kind  = KIND_FILL;
        state_d             = ST_IDLE;
      end else begin
        s_re    = 1'b1;
        s_raddr = level_m1[SAW-1:0];
        state_d = ST_POP;
      end
    end

    if (res_wb) begin
      c_we    = 1'b1;
      c_waddr = scan_a_q;
      c_wdata = res_inc ? CELL_EMPTY : CELL_CAPTURED;
      count_d = count_q + COUNT_W'(res_inc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      dir_q    <= DIR_UP;
      level_q  <= '0;
      scan_v_q <= 1'b0;
      done_q   <= 1'b0;
      grid_w_q <= GRID_RESET;
      grid_h_q <= GRID_RESET;
    end else begin
      state_q  <= state_d;
      dir_q    <= dir_d;
      level_q  <= level_d;
      scan_v_q <= scan_v_d;
      done_q   <= done_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_GRID_WIDTH:  grid_w_q <= cfg_data_i;
          REG_GRID_HEIGHT: grid_h_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_c_q  <= cur_c_d;
    cur_r_q  <= cur_r_d;
    count_q  <= count_d;
    scan_c_q <= scan_c_d;
    scan_r_q <= scan_r_d;
    scan_a_q <= scan_a_d;
    result_q <= result_d;
  end

  grff_ram #(
    .WIDTH (2),
    .DEPTH (CDEPTH)
  ) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .re_i    (c_re),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  grff_ram #(
    .WIDTH (AW),
    .DEPTH (SDEPTH)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .re_i    (s_re),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (level_q == '0))
    else $error("stack not empty while idle");

  a_walk_in_grid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE || state_q == ST_CHECK) |->
      ((CMPW'(cur_c_q) < eff_w) && (CMPW'(cur_r_q) < eff_h)))
    else $error("walk position left the grid");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= SLW'(SDEPTH))
    else $error("stack level beyond depth");

  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

endmodule

`default_nettype wire
